// ===== rtl/prrq_pkg.sv =====
// types and constants shared by the ready-queue scheduler
// no dependencies; imported by prrq_front, prrq_back and the top level
`default_nettype none

package prrq_pkg;

	// fixed widths of the item fields
	localparam int ID_W   = 5;
	localparam int PRIO_W = 3;
	localparam int OP_W   = 2;

	// operation codes as carried on the opcode port
	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_NOP      = 2'd3
	} op_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ADD_W1,
		ST_ADD_W2,
		ST_REM,
		ST_DSP
	} st_t;

	// one result item
	typedef struct packed {
		logic [ID_W-1:0] chosen_id;
		logic            status;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/prrq_fifo.sv =====
// small first-in first-out queue of plain vectors
// no dependencies; used between front and back and on the result side
`default_nettype none

module prrq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/prrq_front.sv =====
// front end: takes items, decodes the operation and folds ids and levels into range
// depends on prrq_pkg
`default_nettype none

module prrq_front #(
	parameter int NUM_LEVELS = 8,
	parameter int NUM_PROCS  = 32,
	localparam int PW = $clog2(NUM_PROCS),
	localparam int LW = $clog2(NUM_LEVELS),
	localparam int CMD_W = prrq_pkg::OP_W + 2 * PW + LW
) (
	input  logic                          push,
	input  logic [prrq_pkg::OP_W-1:0]     opcode,
	input  logic [prrq_pkg::ID_W-1:0]     process_id,
	input  logic [prrq_pkg::PRIO_W-1:0]   priority_req,
	input  logic [prrq_pkg::ID_W-1:0]     active_id,
	input  logic                          q_full,
	output logic                          q_push,
	output logic [CMD_W-1:0]              q_data
);

	import prrq_pkg::*;

	op_t           op;
	logic [PW-1:0] pid;
	logic [PW-1:0] act;
	logic [LW-1:0] lvl;

	// id modulo process count, as a constant table
	function automatic logic [PW-1:0] pid_of(input logic [ID_W-1:0] v);
		logic [PW-1:0] r;
		r = '0;
		for (int i = 0; i < (1 << ID_W); i++) begin
			if (v == ID_W'(i)) begin
				r = PW'(i % NUM_PROCS);
			end
		end
		return r;
	endfunction

	// level modulo level count, as a constant table
	function automatic logic [LW-1:0] lvl_of(input logic [PRIO_W-1:0] v);
		logic [LW-1:0] r;
		r = '0;
		for (int i = 0; i < (1 << PRIO_W); i++) begin
			if (v == PRIO_W'(i)) begin
				r = LW'(i % NUM_LEVELS);
			end
		end
		return r;
	endfunction

	// decode the operation
	always_comb begin
		case (opcode)
			OP_ADD:      op = OP_ADD;
			OP_REMOVE:   op = OP_REMOVE;
			OP_DISPATCH: op = OP_DISPATCH;
			default:     op = OP_NOP;
		endcase
	end

	// fold fields and pack the command
	assign pid    = pid_of(process_id);
	assign act    = pid_of(active_id);
	assign lvl    = lvl_of(priority_req);
	assign q_push = push & ~q_full;
	assign q_data = {op, pid, lvl, act};

endmodule

`default_nettype wire

// ===== rtl/prrq_back.sv =====
// back end: sequencer that updates the level lists and answers dispatch queries
// depends on prrq_pkg; holds the link and level tables as memories
`default_nettype none

module prrq_back #(
	parameter int NUM_LEVELS = 8,
	parameter int NUM_PROCS  = 32,
	localparam int PW = $clog2(NUM_PROCS),
	localparam int LW = $clog2(NUM_LEVELS),
	localparam int CMD_W = prrq_pkg::OP_W + 2 * PW + LW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  logic [CMD_W-1:0]  cmd_data,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output prrq_pkg::res_t    res_data
);

	import prrq_pkg::*;

	st_t             state_q;
	st_t             state_nxt;
	logic [NUM_LEVELS-1:0] nonempty_q;
	logic [PW-1:0]   head_q [NUM_LEVELS];

	// latched command
	op_t             op_q;
	logic [PW-1:0]   pid_q;
	logic [LW-1:0]   lvl_q;
	logic [PW-1:0]   act_q;
	logic [PW-1:0]   h_q;
	logic [PW-1:0]   t_q;
	logic [LW-1:0]   top_q;

	// tables
	logic [PW-1:0]   next_mem [NUM_PROCS];
	logic [PW-1:0]   prev_mem [NUM_PROCS];
	logic [LW-1:0]   lvl_mem  [NUM_PROCS];
	logic [PW-1:0]   next_rd;
	logic [PW-1:0]   prev_rd;
	logic [LW-1:0]   lvl_rd;

	// table access controls
	logic            next_we, prev_we, lvl_we;
	logic [PW-1:0]   next_waddr, prev_waddr, lvl_waddr;
	logic [PW-1:0]   next_wdata, prev_wdata;
	logic [LW-1:0]   lvl_wdata;
	logic [PW-1:0]   next_raddr, prev_raddr, lvl_raddr;

	// head and bitmap controls
	logic            head_we;
	logic [LW-1:0]   head_idx;
	logic [PW-1:0]   head_val;
	logic            bit_set, bit_clr;
	logic [LW-1:0]   bit_idx;
	logic            h_ld, t_ld, top_ld;

	// highest nonempty level
	logic [LW-1:0]   top_lvl;
	logic            any_ready;
	logic            level_busy;
	logic [PW-1:0]   pick;

	always_comb begin
		top_lvl = '0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (nonempty_q[i]) begin
				top_lvl = LW'(i);
			end
		end
	end

	assign any_ready  = |nonempty_q;
	assign level_busy = nonempty_q[lvl_q];
	assign pick       = (lvl_rd == top_q) ? next_rd : head_q[top_q];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty && !res_full) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_ADD:      state_nxt = level_busy ? ST_ADD_W1 : ST_IDLE;
					OP_REMOVE:   state_nxt = ST_REM;
					OP_DISPATCH: state_nxt = any_ready ? ST_DSP : ST_IDLE;
					default:     state_nxt = ST_IDLE;
				endcase
			end
			ST_ADD_W1: state_nxt = ST_ADD_W2;
			ST_ADD_W2: state_nxt = ST_IDLE;
			ST_REM:    state_nxt = ST_IDLE;
			ST_DSP:    state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// outputs and table controls
	always_comb begin
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res_data   = '0;
		next_we    = 1'b0;
		prev_we    = 1'b0;
		lvl_we     = 1'b0;
		next_waddr = pid_q;
		prev_waddr = pid_q;
		lvl_waddr  = pid_q;
		next_wdata = pid_q;
		prev_wdata = pid_q;
		lvl_wdata  = lvl_q;
		next_raddr = pid_q;
		prev_raddr = pid_q;
		lvl_raddr  = pid_q;
		head_we    = 1'b0;
		head_idx   = lvl_q;
		head_val   = pid_q;
		bit_set    = 1'b0;
		bit_clr    = 1'b0;
		bit_idx    = lvl_q;
		h_ld       = 1'b0;
		t_ld       = 1'b0;
		top_ld     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_pop = ~cmd_empty & ~res_full;
			end
			ST_EXEC: begin
				case (op_q)
					OP_ADD: begin
						lvl_we = 1'b1;
						if (!level_busy) begin
							// first process of the level links to itself
							head_we  = 1'b1;
							next_we  = 1'b1;
							prev_we  = 1'b1;
							bit_set  = 1'b1;
							res_push = 1'b1;
						end else begin
							// fetch the tail through the head
							prev_raddr = head_q[lvl_q];
							h_ld       = 1'b1;
						end
					end
					OP_REMOVE: begin
						// reads of the process's links and level go out by default
					end
					OP_DISPATCH: begin
						next_raddr = act_q;
						lvl_raddr  = act_q;
						top_ld     = 1'b1;
						if (!any_ready) begin
							res_push       = 1'b1;
							res_data.status = 1'b1;
						end
					end
					default: begin
						res_push = 1'b1;
					end
				endcase
			end
			ST_ADD_W1: begin
				// new process points at head and tail
				next_we    = 1'b1;
				next_wdata = h_q;
				prev_we    = 1'b1;
				prev_wdata = prev_rd;
				t_ld       = 1'b1;
			end
			ST_ADD_W2: begin
				// tail and head point at the new process
				next_we    = 1'b1;
				next_waddr = t_q;
				prev_we    = 1'b1;
				prev_waddr = h_q;
				res_push   = 1'b1;
			end
			ST_REM: begin
				head_idx = lvl_rd;
				bit_idx  = lvl_rd;
				head_we  = 1'b1;
				res_push = 1'b1;
				if (next_rd == pid_q) begin
					head_val = '0;
					bit_clr  = 1'b1;
				end else begin
					head_val   = next_rd;
					next_we    = 1'b1;
					next_waddr = prev_rd;
					next_wdata = next_rd;
					prev_we    = 1'b1;
					prev_waddr = next_rd;
					prev_wdata = prev_rd;
				end
			end
			ST_DSP: begin
				res_push           = 1'b1;
				res_data.chosen_id = ID_W'(pick);
			end
			default: begin
			end
		endcase
	end

	// control state, head table and level bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			nonempty_q <= '0;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (head_we) begin
				head_q[head_idx] <= head_val;
			end
			if (bit_set) begin
				nonempty_q[bit_idx] <= 1'b1;
			end
			if (bit_clr) begin
				nonempty_q[bit_idx] <= 1'b0;
			end
		end
	end

	// command and working registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			{op_q, pid_q, lvl_q, act_q} <= {op_t'(cmd_data[CMD_W-1 -: OP_W]),
				cmd_data[CMD_W-OP_W-1:0]};
		end
		if (h_ld) begin
			h_q <= head_q[lvl_q];
		end
		if (t_ld) begin
			t_q <= prev_rd;
		end
		if (top_ld) begin
			top_q <= top_lvl;
		end
	end

	// link and level tables, registered reads
	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		next_rd <= next_mem[next_raddr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
		prev_rd <= prev_mem[prev_raddr];
	end

	always_ff @(posedge clk) begin
		if (lvl_we) begin
			lvl_mem[lvl_waddr] <= lvl_wdata;
		end
		lvl_rd <= lvl_mem[lvl_raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/priority_round_robin_ready_queue_unit.sv =====
// top level of the priority round-robin ready-queue scheduler
// depends on prrq_pkg, prrq_front, prrq_fifo and prrq_back
`default_nettype none

// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------------
// items     | push / full        | opcode, process_id, priority_req, active_id
// results   | empty / pop        | chosen_id, status
//
// an item passes the front end into a two-entry command queue, then the back-end
// sequencer with link tables of one write and one read port handles it; an add to
// an empty level, a no-op or a dispatch with nothing ready ends in ST_EXEC; others
// go on through ST_REM, ST_DSP or ST_ADD_W1/W2; results wait in a two-entry queue.
// reset clears the level bitmap and heads at once; the link tables need no clearing.
// a full result queue stalls the sequencer, which in turn backs up the command queue.

module priority_round_robin_ready_queue_unit #(
	parameter int NUM_LEVELS = 8,
	parameter int NUM_PROCS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [prrq_pkg::OP_W-1:0]     opcode,
	input  logic [prrq_pkg::ID_W-1:0]     process_id,
	input  logic [prrq_pkg::PRIO_W-1:0]   priority_req,
	input  logic [prrq_pkg::ID_W-1:0]     active_id,
	output logic                          empty,
	input  logic                          pop,
	output logic [prrq_pkg::ID_W-1:0]     chosen_id,
	output logic                          status
);

	import prrq_pkg::*;

	localparam int PW    = $clog2(NUM_PROCS);
	localparam int LW    = $clog2(NUM_LEVELS);
	localparam int CMD_W = OP_W + 2 * PW + LW;
	localparam int RES_W = $bits(res_t);

	logic             cq_push;
	logic [CMD_W-1:0] cq_wdata;
	logic             cq_full;
	logic             cq_pop;
	logic [CMD_W-1:0] cq_rdata;
	logic             cq_empty;
	logic             rq_push;
	res_t             rq_wdata;
	logic             rq_full;
	res_t             rq_rdata;

	assign full = cq_full;

	// decode and fold
	prrq_front #(
		.NUM_LEVELS (NUM_LEVELS),
		.NUM_PROCS  (NUM_PROCS)
	) u_front (
		.push         (push),
		.opcode       (opcode),
		.process_id   (process_id),
		.priority_req (priority_req),
		.active_id    (active_id),
		.q_full       (cq_full),
		.q_push       (cq_push),
		.q_data       (cq_wdata)
	);

	// command queue between front and back
	prrq_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cq_push),
		.wr_data (cq_wdata),
		.full    (cq_full),
		.rd_en   (cq_pop),
		.rd_data (cq_rdata),
		.empty   (cq_empty)
	);

	// list sequencer
	prrq_back #(
		.NUM_LEVELS (NUM_LEVELS),
		.NUM_PROCS  (NUM_PROCS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cq_empty),
		.cmd_data  (cq_rdata),
		.cmd_pop   (cq_pop),
		.res_full  (rq_full),
		.res_push  (rq_push),
		.res_data  (rq_wdata)
	);

	// result queue
	prrq_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rq_push),
		.wr_data (rq_wdata),
		.full    (rq_full),
		.rd_en   (pop),
		.rd_data (rq_rdata),
		.empty   (empty)
	);

	assign chosen_id = rq_rdata.chosen_id;
	assign status    = rq_rdata.status;

endmodule

`default_nettype wire
